[rtl/core/framed_packet_receiver_top_macros.svh]
// assertion macros for the framed packet receiver
`ifndef FRAMED_PACKET_RECEIVER_TOP_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold in the same cycle as the trigger
`define FPR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpr assertion failed");

// condition must hold in the cycle after the trigger
`define FPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpr assertion failed");

`else

`define FPR_ASSERT_NOW(label, clk, rst, ante, cons)
`define FPR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/core/fpr_pkg.sv]
// shared types, constants and crc functions of the framed packet receiver
package fpr_pkg;

  localparam int unsigned CFG_ADDR_W = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_VALUE   = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_DATA_LEN = 8'd1;

  localparam logic [7:0]  SYNC_RESET    = 8'hA5;
  localparam logic [15:0] MAX_LEN_RESET = 16'd256;

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  localparam logic [15:0] CRC16_POLY = 16'hA001;
  localparam logic [15:0] CRC16_SEED = 16'hFFFF;
  localparam logic [7:0]  CRC8_POLY  = 8'h31;

  // frame bytes besides the data: 4 header, 2 id, 2 reserved, 2 crc
  localparam logic [16:0] FRAME_OVERHEAD = 17'd10;
  localparam logic [16:0] BODY_START     = 17'd4;
  localparam logic [16:0] ID_LOW_POS     = 17'd4;
  localparam logic [16:0] ID_HIGH_POS    = 17'd5;
  localparam logic [16:0] DATA_START     = 17'd8;

  localparam logic REC_DATA = 1'b0;
  localparam logic REC_END  = 1'b1;

  typedef struct packed {
    logic [7:0]  sync_value;
    logic [15:0] max_data_len;
  } cfg_t;

  typedef struct packed {
    logic        record_kind;
    logic [7:0]  data_value;
    logic [15:0] data_index;
    logic [15:0] message_id;
    logic [15:0] data_length;
    logic        frame_good;
  } rec_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [16:0] position;
  } status_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC8_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = {1'b0, c[15:1]} ^ CRC16_POLY;
      end else begin
        c = {1'b0, c[15:1]};
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/fpr_if.sv]
// channel interfaces of the framed packet receiver
interface fpr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fpr_rec_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [7:0]  data_value;
  logic [15:0] data_index;
  logic [15:0] message_id;
  logic [15:0] data_length;
  logic        frame_good;
  modport source (output valid, output record_kind, output data_value, output data_index,
                  output message_id, output data_length, output frame_good, input ready);
  modport sink (input valid, input record_kind, input data_value, input data_index,
                input message_id, input data_length, input frame_good, output ready);
endinterface

interface fpr_cfg_if;
  import fpr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
endinterface

[rtl/core/framed_packet_receiver_top.sv]
// Framed packet receiver. Takes one received byte per request on rx, hunts for the sync
// byte, checks the four-byte header (sync, little-endian length, crc-8 poly 0x31), then
// passes each data byte out on rec as a data record and closes the frame with an end
// record holding the message id, the length and the crc-16 modbus verdict. A header with
// a bad crc is rescanned for a later sync byte; a length above max_data_len drops the
// frame. One byte is taken every cycle: all parsing for a byte is combinational and
// its record lands in a single output register, so rx stalls only while that register
// holds a record that rec has not taken. Records appear in the cycle after their byte.
// Registers sync_value (index 0) and max_data_len (index 1) are written on cfg.
module framed_packet_receiver_top (
  input  logic      clk,
  input  logic      rst,
  fpr_byte_if.sink  rx,
  fpr_rec_if.source rec,
  fpr_cfg_if.sink   cfg
);
  import fpr_pkg::*;

  `include "framed_packet_receiver_top_macros.svh"

  cfg_t    regs;
  rec_t    res;
  status_t status;
  logic    res_valid;
  logic    can_take;
  logic    take;
  logic    end_rec;
  logic    hdr_pos_ok;

  assign rx.ready = can_take;
  assign take     = rx.valid && can_take;

  fpr_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  fpr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx.rx_byte),
    .cfg       (regs),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  fpr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .can_take  (can_take),
    .rec       (rec)
  );

  assign end_rec    = res_valid && res.record_kind == REC_END;
  assign hdr_pos_ok = status.position != 17'd0 && status.position < BODY_START;

  // records only come out of the frame body
  `FPR_ASSERT_NOW(a_rec_from_body, clk, rst, res_valid, status.phase == PH_BODY)
  // an end record sends the parser back to hunting
  `FPR_ASSERT_NEXT(a_end_to_hunt, clk, rst, end_rec, status.phase == PH_HUNT)
  // header collection always sits between the sync byte and the crc byte
  `FPR_ASSERT_NOW(a_hdr_pos, clk, rst, status.phase == PH_HEADER, hdr_pos_ok)
  // body never starts before the id bytes
  `FPR_ASSERT_NOW(a_body_pos, clk, rst, status.phase == PH_BODY, status.position >= BODY_START)

endmodule

[rtl/core/fpr_cfg_regs.sv]
// configuration registers of the framed packet receiver
module fpr_cfg_regs (
  input  logic         clk,
  input  logic         rst,
  fpr_cfg_if.sink      cfg,
  output fpr_pkg::cfg_t regs
);
  import fpr_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sync_value   <= SYNC_RESET;
      regs.max_data_len <= MAX_LEN_RESET;
    end else if (cfg.valid) begin
      case (cfg.addr)
        CFG_SYNC_VALUE:   regs.sync_value   <= cfg.wdata[7:0];
        CFG_MAX_DATA_LEN: regs.max_data_len <= cfg.wdata;
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/fpr_parser.sv]
// frame parser: sync hunt, header check, body crc and record generation
module fpr_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      rx_byte,
  input  fpr_pkg::cfg_t   cfg,
  output logic            res_valid,
  output fpr_pkg::rec_t   res,
  output fpr_pkg::status_t status
);
  import fpr_pkg::*;

  logic [1:0]  phase, phase_next;
  logic [16:0] position, position_next;
  logic [7:0]  hdr [3];
  logic [7:0]  hdr_next [3];
  logic [15:0] crc16_running, crc16_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] id_value, id_next;
  logic [7:0]  crc_low_byte, crc_low_next;

  logic [16:0] pos_inc;
  logic [16:0] total;
  logic [7:0]  hdr_crc;
  logic [15:0] hdr_len;
  logic [15:0] crc16_hdr;

  assign pos_inc   = position + 17'd1;
  assign total     = {1'b0, frame_length} + FRAME_OVERHEAD;
  assign hdr_crc   = crc8_byte(crc8_byte(crc8_byte(8'h00, hdr[0]), hdr[1]), hdr[2]);
  assign hdr_len   = {hdr[2], hdr[1]};
  assign crc16_hdr = crc16_byte(crc16_byte(crc16_byte(crc16_byte(CRC16_SEED, hdr[0]),
                       hdr[1]), hdr[2]), rx_byte);

  always_comb begin
    phase_next        = phase;
    position_next     = position;
    hdr_next          = hdr;
    crc16_next        = crc16_running;
    frame_length_next = frame_length;
    id_next           = id_value;
    crc_low_next      = crc_low_byte;
    res_valid         = 1'b0;
    res               = '0;
    res.message_id    = id_value;
    res.data_length   = frame_length;

    case (phase)
      PH_HEADER: begin
        position_next = pos_inc;
        case (position[1:0])
          2'd1: hdr_next[1] = rx_byte;
          2'd2: hdr_next[2] = rx_byte;
          default: ;
        endcase
        if (position[1:0] == 2'd3) begin
          if (hdr_crc != rx_byte) begin
            // rescan for a sync byte and keep the bytes from it on
            if (hdr[1] == cfg.sync_value) begin
              hdr_next[0]   = hdr[1];
              hdr_next[1]   = hdr[2];
              hdr_next[2]   = rx_byte;
              position_next = 17'd3;
            end else if (hdr[2] == cfg.sync_value) begin
              hdr_next[0]   = hdr[2];
              hdr_next[1]   = rx_byte;
              position_next = 17'd2;
            end else if (rx_byte == cfg.sync_value) begin
              hdr_next[0]   = rx_byte;
              position_next = 17'd1;
            end else begin
              phase_next = PH_HUNT;
            end
          end else if (hdr_len > cfg.max_data_len) begin
            phase_next = PH_HUNT;
          end else begin
            frame_length_next = hdr_len;
            crc16_next        = crc16_hdr;
            position_next     = BODY_START;
            phase_next        = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        position_next = pos_inc;
        if (pos_inc >= total) begin
          res_valid       = 1'b1;
          res.record_kind = REC_END;
          res.frame_good  = (crc16_running == {rx_byte, crc_low_byte});
          phase_next      = PH_HUNT;
        end else if (pos_inc + 17'd1 == total) begin
          crc_low_next = rx_byte;
        end else begin
          crc16_next = crc16_byte(crc16_running, rx_byte);
          if (position == ID_LOW_POS) begin
            id_next[7:0] = rx_byte;
          end else if (position == ID_HIGH_POS) begin
            id_next[15:8] = rx_byte;
          end else if (position >= DATA_START) begin
            res_valid       = 1'b1;
            res.record_kind = REC_DATA;
            res.data_value  = rx_byte;
            res.data_index  = position[15:0] - DATA_START[15:0];
          end
        end
      end
      default: begin
        phase_next = PH_HUNT;
        if (rx_byte == cfg.sync_value) begin
          hdr_next[0]   = rx_byte;
          position_next = 17'd1;
          phase_next    = PH_HEADER;
        end
      end
    endcase

    res_valid = res_valid & take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT;
      position <= '0;
    end else if (take) begin
      phase    <= phase_next;
      position <= position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hdr           <= hdr_next;
      crc16_running <= crc16_next;
      frame_length  <= frame_length_next;
      id_value      <= id_next;
      crc_low_byte  <= crc_low_next;
    end
  end

  assign status.phase    = phase;
  assign status.position = position;

endmodule

[rtl/core/fpr_out_stage.sv]
// output register between the parser and the record channel
module fpr_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_valid,
  input  fpr_pkg::rec_t res,
  output logic          can_take,
  fpr_rec_if.source     rec
);
  import fpr_pkg::*;

  logic valid;
  rec_t data;

  assign can_take = !valid || rec.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_take) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && res_valid) begin
      data <= res;
    end
  end

  assign rec.valid       = valid;
  assign rec.record_kind = data.record_kind;
  assign rec.data_value  = data.data_value;
  assign rec.data_index  = data.data_index;
  assign rec.message_id  = data.message_id;
  assign rec.data_length = data.data_length;
  assign rec.frame_good  = data.frame_good;

endmodule

[bench/tb_framed_packet_receiver_top.sv]
// testbench for the framed packet receiver: random framed byte streams checked by a scoreboard
`timescale 1ns / 1ps

module tb_framed_packet_receiver_top;
  import fpr_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int WHOLE_FRAME = 32'h7fffffff;
  localparam logic [CFG_ADDR_W-1:0] CFG_NO_REG = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TOP_ADDR = 8'hFF;

  logic clk;
  logic rst;

  fpr_byte_if rx_if();
  fpr_rec_if rec_if();
  fpr_cfg_if cfg_if();

  framed_packet_receiver_top dut (
    .clk(clk),
    .rst(rst),
    .rx(rx_if),
    .rec(rec_if),
    .cfg(cfg_if)
  );

  // msb-first header crc, one bit at a time
  function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r = {r[6:0], 1'b0};
      if (fb) r = r ^ CRC8_POLY;
    end
    return r;
  endfunction

  // reflected modbus crc, lsb first
  function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = {1'b0, r[15:1]};
      if (fb) r = r ^ CRC16_POLY;
    end
    return r;
  endfunction

  class frame_scoreboard;
    logic [7:0] sync_byte;
    logic [15:0] len_limit;
    logic [1:0] phase;
    logic [7:0] hdr[4];
    logic [16:0] pos;
    logic [15:0] body_crc;
    logic [15:0] body_len;
    logic [15:0] msg_id;
    logic [7:0] crc_lo;
    rec_t pending[$];
    int errors;

    function new();
      sync_byte = SYNC_RESET;
      len_limit = MAX_LEN_RESET;
      phase = PH_HUNT;
      pos = '0;
      body_crc = CRC16_SEED;
      body_len = '0;
      msg_id = '0;
      crc_lo = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_SYNC_VALUE) sync_byte = val[7:0];
      else if (idx == CFG_MAX_DATA_LEN) len_limit = val;
    endfunction

    // full header in hand: on a bad crc slide to the first later sync byte, if any
    function void close_header();
      logic [7:0] c;
      logic [15:0] len;
      int hit;
      c = crc8_update(crc8_update(crc8_update(8'h00, hdr[0]), hdr[1]), hdr[2]);
      if (c != hdr[3]) begin
        hit = 0;
        for (int i = 1; i < 4; i++) begin
          if (hit == 0 && hdr[i] == sync_byte) hit = i;
        end
        if (hit == 0) begin
          phase = PH_HUNT;
        end else begin
          for (int j = 0; j + hit < 4; j++) hdr[j] = hdr[j + hit];
          pos = 17'(4 - hit);
        end
      end else begin
        len = {hdr[2], hdr[1]};
        if (len > len_limit) begin
          phase = PH_HUNT;
        end else begin
          body_len = len;
          body_crc = CRC16_SEED;
          for (int i = 0; i < 4; i++) body_crc = crc16_update(body_crc, hdr[i]);
          pos = BODY_START;
          phase = PH_BODY;
        end
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [16:0] p;
      logic [16:0] total;
      rec_t r;
      case (phase)
        PH_HEADER: begin
          hdr[pos[1:0]] = b;
          pos = pos + 17'd1;
          if (pos >= BODY_START) close_header();
        end
        PH_BODY: begin
          p = pos;
          pos = p + 17'd1;
          total = FRAME_OVERHEAD + {1'b0, body_len};
          r = '0;
          r.message_id = msg_id;
          r.data_length = body_len;
          if (p + 17'd1 >= total) begin
            r.record_kind = REC_END;
            r.frame_good = (body_crc == {b, crc_lo});
            pending.push_back(r);
            phase = PH_HUNT;
          end else if (p + 17'd2 == total) begin
            crc_lo = b;
          end else begin
            body_crc = crc16_update(body_crc, b);
            if (p == ID_LOW_POS) begin
              msg_id[7:0] = b;
            end else if (p == ID_HIGH_POS) begin
              msg_id[15:8] = b;
            end else if (p >= DATA_START) begin
              r.record_kind = REC_DATA;
              r.data_value = b;
              r.data_index = 16'(p - DATA_START);
              pending.push_back(r);
            end
          end
        end
        default: begin
          // unused phase code behaves as hunting
          phase = PH_HUNT;
          if (b == sync_byte) begin
            hdr[0] = b;
            pos = 17'd1;
            phase = PH_HEADER;
          end
        end
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task cmp_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_record(rec_t got);
      rec_t want;
      if (pending.size() == 0) begin
        report($sformatf("record with nothing pending, kind %0d", got.record_kind));
        return;
      end
      want = pending.pop_front();
      cmp_field("record_kind", 16'(got.record_kind), 16'(want.record_kind));
      cmp_field("data_value", 16'(got.data_value), 16'(want.data_value));
      cmp_field("data_index", got.data_index, want.data_index);
      cmp_field("message_id", got.message_id, want.message_id);
      cmp_field("data_length", got.data_length, want.data_length);
      cmp_field("frame_good", 16'(got.frame_good), 16'(want.frame_good));
    endtask
  endclass

  frame_scoreboard sb = new();

  logic [7:0] cur_sync;
  logic [15:0] cur_max;
  bit fast_mode;
  bit src_busy;
  bit sink_busy;
  int frame_byte_count;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_len(int long_len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, (long_len < 12) ? long_len : 12);
    if (r < 92) return $urandom_range(0, long_len);
    return (int'(cur_max) < long_len) ? int'(cur_max) : long_len;
  endfunction

  // acceptance, scoreboard updates and the no-progress watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (rx_if.valid && rx_if.ready) sb.note_byte(rx_if.rx_byte);
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.addr, cfg_if.wdata);
      if (rec_if.valid && rec_if.ready) begin
        sb.check_record(rec_t'({rec_if.record_kind, rec_if.data_value, rec_if.data_index,
                                rec_if.message_id, rec_if.data_length, rec_if.frame_good}));
      end
      if ((rx_if.valid && rx_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (rec_if.valid && rec_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // record sink with random stalls, busy and calm stretches
  initial begin
    int stall_left;
    int tick;
    stall_left = 0;
    tick = 0;
    sink_busy = 1'b1;
    rec_if.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (fast_mode) begin
        rec_if.ready = 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        rec_if.ready = 1'b0;
        stall_left--;
      end else begin
        rec_if.ready = 1'b1;
        if (sink_busy && $urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
      tick++;
      if (tick % 64 == 0) sink_busy = ($urandom_range(0, 9) < 7);
    end
  end

  task automatic idle_rx(int n);
    rx_if.valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (!fast_mode && src_busy && $urandom_range(0, 7) == 0) idle_rx(pick_gap());
    rx_if.valid = 1'b1;
    rx_if.rx_byte = b;
    do @(posedge clk); while (!rx_if.ready);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.addr = idx;
    cfg_if.wdata = val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
    if (idx == CFG_SYNC_VALUE) cur_sync = val[7:0];
    else if (idx == CFG_MAX_DATA_LEN) cur_max = val;
  endtask

  // hold the sender until every pending record is out, then let the pipe empty
  task automatic settle();
    rx_if.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // builds a frame and sends its first cut bytes
  task automatic send_frame(input logic [7:0] s, input logic [15:0] len, input logic [15:0] id,
                            input bit hdr_err, input bit crc_err, input int cut);
    logic [7:0] fb[$];
    logic [7:0] h;
    logic [15:0] c;
    h = crc8_update(crc8_update(crc8_update(8'h00, s), len[7:0]), len[15:8]);
    if (hdr_err) h = h ^ 8'($urandom_range(1, 255));
    fb.push_back(s); fb.push_back(len[7:0]); fb.push_back(len[15:8]); fb.push_back(h);
    fb.push_back(id[7:0]); fb.push_back(id[15:8]);
    fb.push_back(8'($urandom)); fb.push_back(8'($urandom));
    for (int i = 0; i < int'(len) && fb.size() < cut; i++) fb.push_back(8'($urandom));
    c = CRC16_SEED;
    foreach (fb[k]) c = crc16_update(c, fb[k]);
    if (crc_err) c = c ^ 16'($urandom_range(1, 65535));
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    src_busy = ($urandom_range(0, 9) < 7);
    foreach (fb[k]) begin
      if (k < cut) begin
        send_byte(fb[k]);
        frame_byte_count++;
      end
    end
  endtask

  // mostly well-formed frames, plus slipped headers, bad crcs, drops, cut frames and noise
  task automatic random_traffic(int n, int long_len);
    int start;
    int kind;
    int len;
    start = frame_byte_count;
    while (frame_byte_count - start < n) begin
      kind = $urandom_range(0, 99);
      len = pick_len(long_len);
      if (kind < 12) begin
        // stray sync and junk ahead of a frame forces a header rescan
        send_byte(cur_sync);
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
      end
      if (kind < 62) begin
        send_frame(cur_sync, 16'(len), 16'($urandom), 1'b0, ($urandom_range(0, 3) == 0),
                   WHOLE_FRAME);
      end else if (kind < 72) begin
        send_frame(cur_sync, 16'(len), 16'($urandom), 1'b1, 1'b0, WHOLE_FRAME);
      end else if (kind < 80) begin
        if (cur_max != 16'hFFFF) begin
          send_frame(cur_sync, 16'($urandom_range(int'(cur_max) + 1, 65535)), 16'($urandom),
                     1'b0, 1'b0, 4 + $urandom_range(0, 3));
        end
      end else if (kind < 88) begin
        send_frame(cur_sync, 16'(len), 16'($urandom), 1'b0, 1'b0, $urandom_range(1, len + 9));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(($urandom_range(0, 3) == 0) ? cur_sync : 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = 8'h00;
    cfg_if.valid = 1'b0;
    cfg_if.addr = '0;
    cfg_if.wdata = '0;
    cur_sync = SYNC_RESET;
    cur_max = MAX_LEN_RESET;
    fast_mode = 1'b0;
    src_busy = 1'b1;
    frame_byte_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty frame, rescan into a one-byte frame with bad crc,
    // bad header, oversize length
    send_frame(8'hA5, 16'd0, 16'h0000, 1'b0, 1'b0, WHOLE_FRAME);
    send_byte(8'hA5);
    send_byte(8'h3C);
    send_frame(8'hA5, 16'd1, 16'hFFFF, 1'b0, 1'b1, WHOLE_FRAME);
    send_frame(8'hA5, 16'h0201, 16'h1234, 1'b1, 1'b0, 4);
    send_frame(8'hA5, MAX_LEN_RESET + 16'd1, 16'h0000, 1'b0, 1'b0, 4);

    random_traffic(200, 256);
    settle();

    // unmapped indexes must be ignored
    write_cfg(CFG_NO_REG, 16'h0000);
    write_cfg(CFG_TOP_ADDR, 16'hFFFF);
    write_cfg(CFG_SYNC_VALUE, 16'h0000);
    write_cfg(CFG_MAX_DATA_LEN, 16'h0000);
    random_traffic(100, 0);
    settle();

    write_cfg(CFG_SYNC_VALUE, 16'h00FF);
    write_cfg(CFG_MAX_DATA_LEN, 16'hFFFF);
    // one long frame with no stalls on either side
    fast_mode = 1'b1;
    send_frame(8'hFF, 16'd200, 16'h8001, 1'b0, 1'b0, WHOLE_FRAME);
    fast_mode = 1'b0;
    random_traffic(150, 64);
    settle();

    write_cfg(CFG_SYNC_VALUE, 16'($urandom_range(0, 255)));
    write_cfg(CFG_MAX_DATA_LEN, 16'($urandom_range(1, 40)));
    random_traffic(250, 40);
    settle();

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
